### sv/swmf_pkg.sv
// Shared constants, types and helper functions of the sliding window median filter.
`default_nettype none

package swmf_pkg;

   // Filter geometry and pixel format.
   localparam int WINDOW     = 3;
   localparam int MAX_WIDTH  = 2048;
   localparam int PIXEL_BITS = 32;
   localparam int MAX_ROWS   = 4096;

   localparam int HALF     = WINDOW / 2;
   localparam int AREA     = WINDOW * WINDOW;
   localparam int LB_COUNT = WINDOW - 1;
   localparam int MED_IDX  = AREA / 2;

   // Widths of the fixed word fields.
   localparam int WORD_BITS      = 32;
   localparam int ROW_FIELD_BITS = 12;
   localparam int COL_FIELD_BITS = 11;

   // Counter and register widths.
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int WB        = COL_BITS + 1;
   localparam int ROW_BITS  = 12;
   localparam int H_BITS    = 13;
   localparam int LW_BITS   = 12;
   localparam int SLOT_BITS = (LB_COUNT > 1) ? $clog2(LB_COUNT) : 1;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 13;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_WIDTH   = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'd1;
   localparam int LINE_WIDTH_RESET   = 640;
   localparam int FRAME_HEIGHT_RESET = 480;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [AREA-1:0][PIXEL_BITS-1:0] window_type;
   typedef logic [SLOT_BITS-1:0] slot_type;

   // Position data that travels with a window through the sorting chain.
   typedef struct packed {
      logic [ROW_FIELD_BITS-1:0] row;
      logic [COL_FIELD_BITS-1:0] col;
      logic                      last;
   } meta_type;

   // Next line buffer slot, wrapping over the buffer count.
   function automatic slot_type slot_next(input slot_type s);
      slot_type r;
      if (s == SLOT_BITS'(LB_COUNT - 1)) begin
         r = '0;
      end else begin
         r = s + 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/swmf_req_if.sv
// Input channel of the median filter: one pixel word per handshake.
`default_nettype none

interface swmf_req_if import swmf_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] pixel_value;
   logic                 frame_start;

   modport source (output valid, output pixel_value, output frame_start, input ready);
   modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

`default_nettype wire

### sv/swmf_rsp_if.sv
// Result channel of the median filter: one median word with its position.
`default_nettype none

interface swmf_rsp_if import swmf_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [WORD_BITS-1:0]      median_value;
   logic [ROW_FIELD_BITS-1:0] center_row;
   logic [COL_FIELD_BITS-1:0] center_column;
   logic                      last_in_frame;

   modport source (output valid, output median_value, output center_row,
                   output center_column, output last_in_frame, input ready);
   modport sink   (input valid, input median_value, input center_row,
                   input center_column, input last_in_frame, output ready);
endinterface

`default_nettype wire

### sv/swmf_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
`default_nettype none

module swmf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   assign rdata = rdata_ff;

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

endmodule

`default_nettype wire

### sv/swmf_sort_cell.sv
// One cell of the odd-even transposition sorting chain.
`default_nettype none

module swmf_sort_cell import swmf_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       odd_phase,
   input  wire logic       up_valid,
   output logic            up_ready,
   input  wire window_type up_vals,
   input  wire meta_type   up_meta,
   output logic            dn_valid,
   input  wire logic       dn_ready,
   output window_type      dn_vals,
   output meta_type        dn_meta
);

   logic       valid_ff;
   window_type vals_ff;
   window_type vals_in;
   meta_type   meta_ff;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_vals  = vals_ff;
   assign dn_meta  = meta_ff;

   // Compare-exchange on every pair that starts at this cell's parity.
   always_comb begin
      vals_in = up_vals;
      for (int i = 0; i < AREA - 1; i++) begin
         if ((1'(i) == odd_phase) && (up_vals[i] > up_vals[i+1])) begin
            vals_in[i]   = up_vals[i+1];
            vals_in[i+1] = up_vals[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         vals_ff <= vals_in;
         meta_ff <= up_meta;
      end
   end

endmodule

`default_nettype wire

### sv/sliding_window_median_filter_top.sv
// A result leaves after the word that completes its window is accepted, passing through
// the line buffer RAM read and window load, the sorting chain and the output register.
// One word is accepted per clock while nothing stalls; stalls on the result side back up
// through the chain and fill its empty cells before the input is held off.
// Reset clears the position counters, the window and the chain, and sets the line width
// to 640 and the frame height to 480; line buffers hold garbage until written.
`default_nettype none

module sliding_window_median_filter_top import swmf_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   swmf_req_if.sink                       req_ch,
   swmf_rsp_if.source                     rsp_ch,
   input  wire logic                      csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   // Configuration, stored already clamped to the legal range.
   logic [WB-1:0]     width_ff, width_in;
   logic [H_BITS-1:0] height_ff, height_in;
   logic [LW_BITS-1:0] csr_lw;
   logic [H_BITS-1:0]  csr_fh;

   // Position counters.
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   slot_type            slot_ff, slot_in;

   logic [ROW_BITS-1:0] pre_row, cur_row;
   logic [COL_BITS-1:0] pre_col, mid_col, cur_col;
   slot_type            pre_slot, mid_slot, cur_slot;
   logic [H_BITS-1:0]   mid_row, post_row;
   logic [WB-1:0]       post_col;
   logic                cur_emit;
   meta_type            cur_meta;

   // Load stage: the accepted word waits here for its line buffer reads.
   logic      accept;
   logic      req_rdy;
   logic      s1_v_ff;
   pixel_type s1_pix_ff;
   slot_type  s1_slot_ff;
   logic      s1_emit_ff;
   meta_type  s1_meta_ff;
   logic      adv1;

   pixel_type line_rd [LB_COUNT];
   logic [SLOT_BITS:0] tap_idx [LB_COUNT];
   pixel_type new_col [WINDOW];

   window_type win_ff, win_in;

   // Sorting chain wiring.
   logic       c_v   [AREA];
   logic       c_rdy [AREA];
   window_type c_vals [AREA];
   meta_type   c_meta [AREA];

   // Output register.
   logic      out_v_ff;
   pixel_type out_med_ff;
   meta_type  out_meta_ff;
   logic      out_rdy;

   // Clamp configuration writes.
   always_comb begin
      csr_lw = csr_wdata[LW_BITS-1:0];
      csr_fh = csr_wdata[H_BITS-1:0];
      if (csr_lw == '0) begin
         width_in = WB'(1);
      end else if (32'(csr_lw) > MAX_WIDTH) begin
         width_in = WB'(MAX_WIDTH);
      end else begin
         width_in = WB'(csr_lw);
      end
      if (csr_fh == '0) begin
         height_in = H_BITS'(1);
      end else if (32'(csr_fh) > MAX_ROWS) begin
         height_in = H_BITS'(MAX_ROWS);
      end else begin
         height_in = csr_fh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WB'(LINE_WIDTH_RESET);
         height_ff <= H_BITS'(FRAME_HEIGHT_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LINE_WIDTH:   width_ff  <= width_in;
            CSR_FRAME_HEIGHT: height_ff <= height_in;
            default: ;
         endcase
      end
   end

   // Position of the incoming word, then the position of the word after it.
   always_comb begin
      pre_row  = req_ch.frame_start ? '0 : row_ff;
      pre_col  = req_ch.frame_start ? '0 : col_ff;
      pre_slot = req_ch.frame_start ? '0 : slot_ff;

      if (WB'(pre_col) >= width_ff) begin
         mid_col  = '0;
         mid_row  = H_BITS'(pre_row) + 1'b1;
         mid_slot = slot_next(pre_slot);
      end else begin
         mid_col  = pre_col;
         mid_row  = H_BITS'(pre_row);
         mid_slot = pre_slot;
      end

      if (mid_row >= height_ff) begin
         cur_row  = '0;
         cur_slot = '0;
      end else begin
         cur_row  = mid_row[ROW_BITS-1:0];
         cur_slot = mid_slot;
      end
      cur_col = mid_col;

      post_col = WB'(cur_col) + 1'b1;
      post_row = H_BITS'(cur_row) + 1'b1;
      if (post_col >= width_ff) begin
         col_in = '0;
         if (post_row >= height_ff) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = post_row[ROW_BITS-1:0];
            slot_in = slot_next(cur_slot);
         end
      end else begin
         col_in  = post_col[COL_BITS-1:0];
         row_in  = cur_row;
         slot_in = cur_slot;
      end

      cur_emit = (cur_row >= ROW_BITS'(WINDOW - 1)) && (cur_col >= COL_BITS'(WINDOW - 1));
      cur_meta.row  = ROW_FIELD_BITS'(cur_row - ROW_BITS'(HALF));
      cur_meta.col  = COL_FIELD_BITS'(cur_col - COL_BITS'(HALF));
      cur_meta.last = (H_BITS'(cur_row) == height_ff - 1'b1) &&
                      (WB'(cur_col) == width_ff - 1'b1);
   end

   assign accept       = req_ch.valid && req_rdy;
   assign req_ch.ready = req_rdy;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         slot_ff <= '0;
      end else if (accept) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         slot_ff <= slot_in;
      end
   end

   // Line buffers: all are read at the current column, one is written with the new word.
   for (genvar b = 0; b < LB_COUNT; b++) begin : g_line
      swmf_ram #(
         .WIDTH (PIXEL_BITS),
         .DEPTH (MAX_WIDTH)
      ) u_line (
         .clock (clock),
         .we    (accept && (cur_slot == SLOT_BITS'(b))),
         .waddr (cur_col),
         .wdata (req_ch.pixel_value[PIXEL_BITS-1:0]),
         .re    (accept),
         .raddr (cur_col),
         .rdata (line_rd[b])
      );
   end

   // A word without a result may leave the load stage even while the chain is full.
   assign adv1    = s1_v_ff && (!s1_emit_ff || c_rdy[0]);
   assign req_rdy = !s1_v_ff || adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (req_rdy) begin
         s1_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_ch.pixel_value[PIXEL_BITS-1:0];
         s1_slot_ff <= cur_slot;
         s1_emit_ff <= cur_emit;
         s1_meta_ff <= cur_meta;
      end
   end

   // New window column: oldest buffered row on top, the new word at the bottom.
   always_comb begin
      for (int r = 0; r < LB_COUNT; r++) begin
         tap_idx[r] = {1'b0, s1_slot_ff} + (SLOT_BITS + 1)'(r);
         if (tap_idx[r] >= (SLOT_BITS + 1)'(LB_COUNT)) begin
            tap_idx[r] = tap_idx[r] - (SLOT_BITS + 1)'(LB_COUNT);
         end
         new_col[r] = line_rd[tap_idx[r][SLOT_BITS-1:0]];
      end
      new_col[WINDOW-1] = s1_pix_ff;
   end

   // Shift the window left by one column and load the new one on the right.
   always_comb begin
      for (int r = 0; r < WINDOW; r++) begin
         for (int c = 0; c < WINDOW - 1; c++) begin
            win_in[r*WINDOW+c] = win_ff[r*WINDOW+c+1];
         end
         win_in[r*WINDOW+WINDOW-1] = new_col[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (adv1) begin
         win_ff <= win_in;
      end
   end

   // Sorting chain: one compare-exchange layer per cell, alternating parity.
   for (genvar k = 0; k < AREA; k++) begin : g_cell
      logic       in_v;
      window_type in_vals;
      meta_type   in_meta;
      logic       down_rdy;

      if (k == 0) begin : g_head
         assign in_v    = s1_v_ff && s1_emit_ff;
         assign in_vals = win_in;
         assign in_meta = s1_meta_ff;
      end else begin : g_body
         assign in_v    = c_v[k-1];
         assign in_vals = c_vals[k-1];
         assign in_meta = c_meta[k-1];
      end

      if (k == AREA - 1) begin : g_tail
         assign down_rdy = out_rdy;
      end else begin : g_mid
         assign down_rdy = c_rdy[k+1];
      end

      swmf_sort_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .odd_phase (1'(k % 2)),
         .up_valid  (in_v),
         .up_ready  (c_rdy[k]),
         .up_vals   (in_vals),
         .up_meta   (in_meta),
         .dn_valid  (c_v[k]),
         .dn_ready  (down_rdy),
         .dn_vals   (c_vals[k]),
         .dn_meta   (c_meta[k])
      );
   end

   // Output register takes the middle element of the sorted window.
   assign out_rdy = !out_v_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_rdy) begin
         out_v_ff <= c_v[AREA-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && c_v[AREA-1]) begin
         out_med_ff  <= c_vals[AREA-1][MED_IDX];
         out_meta_ff <= c_meta[AREA-1];
      end
   end

   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.median_value  = WORD_BITS'(out_med_ff);
   assign rsp_ch.center_row    = out_meta_ff.row;
   assign rsp_ch.center_column = out_meta_ff.col;
   assign rsp_ch.last_in_frame = out_meta_ff.last;

endmodule

`default_nettype wire
